/* design/irpft_pkg.sv */
// Package for the IR pulse frame transmitter: word types, frame constants,
// mode codes and parameter defaults. Depends on nothing.
package irpft_pkg;

  localparam int MSG_W           = 20;
  localparam int DATA_BITS       = 21;
  localparam int POS_W           = 5;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int START_SLOTS_DEF = 3;

  localparam logic MODE_ENQ  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] sender_id;
    logic [7:0] payload;
    logic [1:0] hop_count;
    logic       original_sender_flag;
    logic       base_flag;
  } in_word_t;

  typedef struct packed {
    logic       led_level;
    logic       sending;
    logic       dropped;
    logic [3:0] queue_level;
  } out_word_t;

endpackage

/* design/ir_pulse_frame_transmitter.sv */
// IR pulse frame transmitter top level: message queue in a synchronous
// memory, pulse slot sequencer and a two-word output skid buffer.
// Depends on irpft_pkg.
//
//   channel  direction  handshake             word type
//   in_      input      in_valid / in_stall   irpft_pkg::in_word_t
//   out_     output     out_valid / out_stall irpft_pkg::out_word_t
//
// Every accepted word, enqueue or tick, yields one result word; one word is
// taken each cycle unless in_stall is high, so the block runs at one word
// per clock while out_stall is low. Results are registered in the output
// buffer. Reset (rst_n low, synchronous) empties queue and output buffer and
// stops any frame; the queue memory itself is not cleared. While the result
// side stalls, up to two result words are held; in_stall rises only when both are occupied.
module ir_pulse_frame_transmitter #(
  parameter int QUEUE_DEPTH = irpft_pkg::QUEUE_DEPTH_DEF,
  parameter int START_SLOTS = irpft_pkg::START_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  irpft_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output irpft_pkg::out_word_t out_word
);
  import irpft_pkg::*;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int PH_W    = ($clog2(START_SLOTS + 1) > 2) ? $clog2(START_SLOTS + 1) : 2;
  localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(QUEUE_DEPTH);
  localparam logic [PH_W-1:0]  PH_START   = PH_W'(START_SLOTS);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(DATA_BITS);

  // Message queue memory: one write port for enqueues, one registered read
  // port used when a frame is loaded.
  logic [MSG_W-1:0] msg_mem [QUEUE_DEPTH];
  logic [MSG_W-1:0] rd_data_r;
  logic             load_pend_r;

  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [PTR_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DATA_BITS-1:0] frame_bits_r;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [PH_W-1:0]      ph_r, ph_nxt;
  logic                 busy_r, busy_nxt;
  logic                 led_r, led_nxt;

  logic                 acc;
  logic                 wr_en;
  logic                 load;
  logic                 dropped;
  logic [POS_W-1:0]     bit_idx;
  logic                 cur_bit;
  logic                 bit_last;
  logic [MSG_W-1:0]     wr_msg;
  logic [CNT_W+3:0]     cnt_ext;
  out_word_t            res;

  // Output skid buffer: the main register drives the port, the skid
  // register catches a result while the port is stalled.
  out_word_t main_r, skid_r;
  logic      main_vld_r, skid_vld_r;

  assign in_stall  = skid_vld_r;
  assign acc       = in_valid & ~skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_word  = main_r;

  assign wr_msg  = {in_word.base_flag, in_word.original_sender_flag, in_word.hop_count,
                    in_word.payload, in_word.sender_id};
  assign bit_idx = pos_r - POS_W'(1);
  // After a load the frame bits pass through rd_data_r, then frame_bits_r.
  // With START_SLOTS >= 1 the preamble lets both settle before the first data slot.
  assign cur_bit = frame_bits_r[bit_idx];

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    ph_nxt   = ph_r;
    busy_nxt = busy_r;
    led_nxt  = led_r;
    wr_en    = 1'b0;
    load     = 1'b0;
    dropped  = 1'b0;
    bit_last = 1'b0;

    if (acc) begin
      if (in_word.mode == MODE_ENQ) begin
        if (cnt_r == CNT_FULL) begin
          dropped = 1'b1;
        end else begin
          wr_en    = 1'b1;
          tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end else begin
        if (!busy_r && cnt_r != '0) begin
          load     = 1'b1;
          head_nxt = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
          cnt_nxt  = cnt_r - CNT_W'(1);
          pos_nxt  = '0;
          ph_nxt   = '0;
          busy_nxt = 1'b1;
        end
        if (busy_nxt) begin
          if (pos_nxt == '0) begin
            // Preamble: start slots high, then one low slot.
            if (ph_nxt < PH_START) begin
              led_nxt = 1'b1;
              ph_nxt  = ph_nxt + PH_W'(1);
            end else begin
              led_nxt = 1'b0;
              ph_nxt  = '0;
              pos_nxt = POS_W'(1);
            end
          end else if (pos_nxt <= POS_LAST) begin
            // A one is high,high,low and a zero is high,low.
            bit_last = cur_bit ? (ph_nxt >= PH_W'(2)) : (ph_nxt >= PH_W'(1));
            led_nxt  = (ph_nxt == '0) || (cur_bit && ph_nxt == PH_W'(1));
            if (bit_last) begin
              ph_nxt  = '0;
              pos_nxt = pos_nxt + POS_W'(1);
            end else begin
              ph_nxt  = ph_nxt + PH_W'(1);
            end
          end else begin
            // End marker ends the frame.
            busy_nxt = 1'b0;
            led_nxt  = 1'b0;
            pos_nxt  = '0;
            ph_nxt   = '0;
          end
        end
      end
    end

    cnt_ext         = {4'b0, cnt_nxt};
    res.led_level   = led_nxt;
    res.sending     = busy_nxt;
    res.dropped     = dropped;
    res.queue_level = cnt_ext[3:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      msg_mem[tail_r] <= wr_msg;
    end
    if (load) begin
      rd_data_r <= msg_mem[head_r];
    end
    if (load_pend_r) begin
      frame_bits_r <= {^rd_data_r, rd_data_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      pos_r       <= '0;
      ph_r        <= '0;
      busy_r      <= 1'b0;
      led_r       <= 1'b0;
      load_pend_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      ph_r        <= ph_nxt;
      busy_r      <= busy_nxt;
      led_r       <= led_nxt;
      load_pend_r <= load;
    end
  end

  // Skid buffer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (main_vld_r && out_stall) begin
        if (acc) begin
          skid_vld_r <= 1'b1;
        end
      end else if (skid_vld_r) begin
        main_vld_r <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        main_vld_r <= acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (main_vld_r && out_stall) begin
      if (acc) begin
        skid_r <= res;
      end
    end else if (skid_vld_r) begin
      main_r <= skid_r;
    end else if (acc) begin
      main_r <= res;
    end
  end

endmodule
